@@ rtl/exchange_sort_ascending_defines.svh @@
// Assertion macros used by the checker file.
`ifndef EXCHANGE_SORT_ASCENDING_DEFINES_SVH
`define EXCHANGE_SORT_ASCENDING_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while in reset
`define EXSORT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("exsort assertion failed");

// Next-cycle implication, sampled on clk_i, off while in reset
`define EXSORT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("exsort assertion failed");

`endif

@@ rtl/exsort_pkg.sv @@
package exsort_pkg;

  // Number of stored elements per set
  localparam int unsigned Depth = 16;
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned DataW = 16;

  // Input request
  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    last;
  } req_t;

  // Result
  typedef struct packed {
    logic signed [DataW-1:0] value_res;
    logic                    last_res;
    logic                    dropped;
  } res_t;

  // Element store access, one write and one read port
  typedef struct packed {
    logic                    we;
    logic [IdxW-1:0]         waddr;
    logic signed [DataW-1:0] wdata;
    logic [IdxW-1:0]         raddr;
  } ram_req_t;

  // Result control from the sequencer
  typedef struct packed {
    logic valid;
    logic last;
    logic dropped;
  } emit_t;

endpackage

@@ rtl/exchange_sort_ascending.sv @@
// Exchange sort, ascending, on sets of up to Depth signed 16-bit values.
// Loading takes a request whenever start is high; busy stays low while a set is collected.
// After the closing request the block stays busy: one compare per cycle on the single
// comparator over a one-read, one-write store, then one result per cycle.
// Reset clears the fill count, overflow flag and sequencer; results cannot be stalled.
module exchange_sort_ascending (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  exsort_pkg::req_t req_i,
  output logic             res_valid_o,
  output exsort_pkg::res_t res_o
);
  import exsort_pkg::*;

  ram_req_t                ram_req;
  emit_t                   emit;
  logic signed [DataW-1:0] rdata;
  logic                    res_valid_q;
  res_t                    res_q;

  exsort_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .req_i   (req_i),
    .rdata_i (rdata),
    .busy_o  (busy),
    .ram_o   (ram_req),
    .emit_o  (emit)
  );

  exsort_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (rdata)
  );

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= emit.valid;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      res_q.value_res <= rdata;
      res_q.last_res  <= emit.last;
      res_q.dropped   <= emit.dropped;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

@@ rtl/exsort_ram.sv @@
module exsort_ram (
  input  logic                               clk_i,
  input  exsort_pkg::ram_req_t               req_i,
  output logic signed [exsort_pkg::DataW-1:0] rdata_o
);
  import exsort_pkg::*;

  logic signed [DataW-1:0] mem_q [Depth];
  logic signed [DataW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/exsort_ctrl.sv @@
module exsort_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  exsort_pkg::req_t                    req_i,
  input  logic signed [exsort_pkg::DataW-1:0] rdata_i,
  output logic                                busy_o,
  output exsort_pkg::ram_req_t                ram_o,
  output exsort_pkg::emit_t                   emit_o
);
  import exsort_pkg::*;

  typedef enum logic [6:0] {
    S_LOAD  = 7'b0000001,
    S_FETCH = 7'b0000010,
    S_FIRST = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_PLACE = 7'b0010000,
    S_PRIME = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_e;

  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  state_e                  state_q, state_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic                    ovf_q, ovf_d;
  logic [IdxW-1:0]         i_q, i_d;
  logic [IdxW-1:0]         j_q, j_d;
  logic signed [DataW-1:0] cur_q, cur_d;
  logic [IdxW-1:0]         last_idx;
  logic [IdxW-1:0]         i_nxt;
  logic [IdxW-1:0]         j_nxt;
  logic                    smaller;

  // Position of the final stored element
  assign last_idx = IdxW'(cnt_q - CntW'(1));
  assign i_nxt    = i_q + IdxW'(1);
  assign j_nxt    = j_q + IdxW'(1);

  // Shared compare: strictly smaller moves toward the front
  assign smaller  = (rdata_i < cur_q);

  assign busy_o   = (state_q != S_LOAD);

  // Sequencer
  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    ovf_d          = ovf_q;
    i_d            = i_q;
    j_d            = j_q;
    cur_d          = cur_q;
    ram_o.we       = 1'b0;
    ram_o.waddr    = j_q;
    ram_o.wdata    = cur_q;
    ram_o.raddr    = j_q;
    emit_o.valid   = 1'b0;
    emit_o.last    = 1'b0;
    emit_o.dropped = ovf_q;

    unique case (state_q)
      S_LOAD: begin
        if (start_i) begin
          if (cnt_q < DepthCnt) begin
            ram_o.we    = 1'b1;
            ram_o.waddr = cnt_q[IdxW-1:0];
            ram_o.wdata = req_i.value;
            cnt_d       = cnt_q + CntW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (req_i.last) begin
            i_d     = '0;
            state_d = (cnt_d == CntW'(1)) ? S_PRIME : S_FETCH;
          end
        end
      end
      S_FETCH: begin
        ram_o.raddr = i_q;
        state_d     = S_FIRST;
      end
      S_FIRST: begin
        cur_d       = rdata_i;
        ram_o.raddr = i_nxt;
        j_d         = i_nxt;
        state_d     = S_SCAN;
      end
      S_SCAN: begin
        // swap: the larger value goes back to slot j
        if (smaller) begin
          ram_o.we    = 1'b1;
          ram_o.waddr = j_q;
          ram_o.wdata = cur_q;
          cur_d       = rdata_i;
        end
        if (j_q == last_idx) begin
          state_d = S_PLACE;
        end else begin
          ram_o.raddr = j_nxt;
          j_d         = j_nxt;
        end
      end
      S_PLACE: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = i_q;
        ram_o.wdata = cur_q;
        i_d         = i_nxt;
        if (i_nxt == last_idx) begin
          state_d = S_PRIME;
        end else begin
          ram_o.raddr = i_nxt;
          state_d     = S_FIRST;
        end
      end
      S_PRIME: begin
        ram_o.raddr = '0;
        j_d         = '0;
        state_d     = S_EMIT;
      end
      S_EMIT: begin
        emit_o.valid = 1'b1;
        emit_o.last  = (j_q == last_idx);
        if (j_q == last_idx) begin
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = S_LOAD;
        end else begin
          ram_o.raddr = j_nxt;
          j_d         = j_nxt;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  // Running minimum for the current position
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

endmodule

@@ rtl/exsort_chk.sv @@
`include "exchange_sort_ascending_defines.svh"

module exsort_chk (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start_i,
  input logic             busy_i,
  input exsort_pkg::req_t req_i,
  input logic             res_valid_i,
  input exsort_pkg::res_t res_i
);
  import exsort_pkg::*;

  // A closing request starts the sort
  `EXSORT_ASSERT_NEXT(a_close_busy, start_i && !busy_i && req_i.last, busy_i)

  // Results of one set come back to back
  `EXSORT_ASSERT_NEXT(a_burst, res_valid_i && !res_i.last_res, res_valid_i)

  // The overflow flag is the same across a set
  `EXSORT_ASSERT_NEXT(a_drop_const, res_valid_i && !res_i.last_res,
                      res_i.dropped == $past(res_i.dropped))

  // Final result ends the burst
  `EXSORT_ASSERT_NEXT(a_last_gap, res_valid_i && res_i.last_res, !res_valid_i)

endmodule

bind exchange_sort_ascending exsort_chk u_exsort_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start),
  .busy_i      (busy),
  .req_i       (req_i),
  .res_valid_i (res_valid_o),
  .res_i       (res_o)
);
